// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the matrix multiply block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed in matrix multiply block.");

// The consequent must hold in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed in matrix multiply block.");

`endif

// ===== rtl/mm_pkg.sv =====
// Package with the shared types and constants of the matrix multiply block.
`default_nettype none
package mm_pkg;

   localparam int CMD_WIDTH       = 2;
   localparam int IDX_WIDTH       = 3;
   localparam int ELEM_WIDTH      = 35;
   localparam int DIM_REG_WIDTH   = 4;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CMD_WIDTH-1:0] CMD_LOAD_A = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_LOAD_B = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_START  = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROWS_A = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COLS_A = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROWS_B = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COLS_B = 2'd3;

   localparam logic [DIM_REG_WIDTH-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic [DIM_REG_WIDTH-1:0] rows_a;
      logic [DIM_REG_WIDTH-1:0] cols_a;
      logic [DIM_REG_WIDTH-1:0] rows_b;
      logic [DIM_REG_WIDTH-1:0] cols_b;
   } mm_dims_type;

   typedef struct packed {
      logic a_we;
      logic b_we;
   } mm_wr_type;

endpackage
`default_nettype wire

// ===== rtl/mm_req_if.sv =====
// Request channel interface of the matrix multiply block.
`default_nettype none
interface mm_req_if
   import mm_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic [CMD_WIDTH-1:0]          command;
   logic [IDX_WIDTH-1:0]          row;
   logic [IDX_WIDTH-1:0]          col;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output command, output row, output col, output value,
                   input ready);
   modport sink (input valid, input command, input row, input col, input value,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/mm_rsp_if.sv =====
// Response channel interface of the matrix multiply block.
`default_nettype none
interface mm_rsp_if
   import mm_pkg::*;
;
   logic                         valid;
   logic                         ready;
   logic [IDX_WIDTH-1:0]         out_row;
   logic [IDX_WIDTH-1:0]         out_col;
   logic signed [ELEM_WIDTH-1:0] element;
   logic                         last;
   logic                         error;

   modport source (output valid, output out_row, output out_col, output element,
                   output last, output error, input ready);
   modport sink (input valid, input out_row, input out_col, input element,
                 input last, input error, output ready);
endinterface
`default_nettype wire

// ===== rtl/matrix_multiply_core.sv =====
// Load requests are accepted back to back while the core is idle. A start request holds off
// further requests until its last or error response is loaded into the response register.
// Each element of C is computed by the single multiply-accumulate unit, which takes one
// product per cycle from the two memories in the run state and starts no new element until
// the current one is emitted. A dimension mismatch yields one error response instead.
// Synchronous reset clears control state and the accumulator and sets every dimension to 8.
`default_nettype none
module matrix_multiply_core
   import mm_pkg::*;
#(
   parameter int MAX_DIM     = 8,
   parameter int VALUE_WIDTH = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   mm_req_if.sink                     req_bus,
   mm_rsp_if.source                   rsp_bus,
   input  wire                        csr_we,
   input  wire [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire [DIM_REG_WIDTH-1:0]    csr_wdata
);
   localparam int DW = $clog2(MAX_DIM);
   localparam int AW = $clog2(MAX_DIM * MAX_DIM);

   mm_dims_type                   dims_ff;
   mm_wr_type                     wr_ctl;
   logic                          busy;
   logic                          req_fire;
   logic                          in_range;
   logic                          start;
   logic [AW-1:0]                 wr_addr;
   logic [AW-1:0]                 rd_addr_a;
   logic [AW-1:0]                 rd_addr_b;
   logic signed [VALUE_WIDTH-1:0] rd_data_a;
   logic signed [VALUE_WIDTH-1:0] rd_data_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= '{rows_a: DIM_RESET, cols_a: DIM_RESET,
                      rows_b: DIM_RESET, cols_b: DIM_RESET};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROWS_A: dims_ff.rows_a <= csr_wdata;
            REG_COLS_A: dims_ff.cols_a <= csr_wdata;
            REG_ROWS_B: dims_ff.rows_b <= csr_wdata;
            REG_COLS_B: dims_ff.cols_b <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_bus.ready = !busy;
   assign req_fire      = req_bus.valid && !busy;
   assign in_range      = ({1'b0, req_bus.row} < (IDX_WIDTH + 1)'(MAX_DIM))
                       && ({1'b0, req_bus.col} < (IDX_WIDTH + 1)'(MAX_DIM));
   assign wr_addr       = AW'(req_bus.row[DW-1:0]) * AW'(MAX_DIM) + AW'(req_bus.col[DW-1:0]);

   always_comb begin
      wr_ctl.a_we = 1'b0;
      wr_ctl.b_we = 1'b0;
      start       = 1'b0;
      if (req_fire) begin
         unique case (req_bus.command)
            CMD_LOAD_A: wr_ctl.a_we = in_range;
            CMD_LOAD_B: wr_ctl.b_we = in_range;
            CMD_START:  start       = 1'b1;
            default: begin
            end
         endcase
      end
   end

   mm_store #(
      .MAX_DIM     (MAX_DIM),
      .VALUE_WIDTH (VALUE_WIDTH),
      .ADDR_WIDTH  (AW)
   ) u_store (
      .clock     (clock),
      .wr_ctl    (wr_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (req_bus.value),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mm_engine #(
      .MAX_DIM     (MAX_DIM),
      .VALUE_WIDTH (VALUE_WIDTH),
      .ADDR_WIDTH  (AW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .dims        (dims_ff),
      .busy        (busy),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .rd_data_a   (rd_data_a),
      .rd_data_b   (rd_data_b),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_row     (rsp_bus.out_row),
      .rsp_col     (rsp_bus.out_col),
      .rsp_element (rsp_bus.element),
      .rsp_last    (rsp_bus.last),
      .rsp_error   (rsp_bus.error)
   );
endmodule
`default_nettype wire

// ===== rtl/mm_store.sv =====
// Matrix A and matrix B memories with one write port and registered read ports.
`default_nettype none
module mm_store
   import mm_pkg::*;
#(
   parameter int MAX_DIM     = 8,
   parameter int VALUE_WIDTH = 16,
   parameter int ADDR_WIDTH  = 6
) (
   input  wire                           clock,
   input  mm_wr_type                     wr_ctl,
   input  wire [ADDR_WIDTH-1:0]          wr_addr,
   input  wire signed [VALUE_WIDTH-1:0]  wr_data,
   input  wire [ADDR_WIDTH-1:0]          rd_addr_a,
   input  wire [ADDR_WIDTH-1:0]          rd_addr_b,
   output logic signed [VALUE_WIDTH-1:0] rd_data_a,
   output logic signed [VALUE_WIDTH-1:0] rd_data_b
);
   localparam int DEPTH = MAX_DIM * MAX_DIM;

   logic signed [VALUE_WIDTH-1:0] mem_a [DEPTH];
   logic signed [VALUE_WIDTH-1:0] mem_b [DEPTH];
   logic signed [VALUE_WIDTH-1:0] rd_data_a_ff;
   logic signed [VALUE_WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_ctl.a_we) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.b_we) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_data_b_ff <= mem_b[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;
endmodule
`default_nettype wire

// ===== rtl/mm_engine.sv =====
// Multiply sequencer with the multiply-accumulate pipeline and the response register.
`default_nettype none
module mm_engine
   import mm_pkg::*;
#(
   parameter int MAX_DIM     = 8,
   parameter int VALUE_WIDTH = 16,
   parameter int ADDR_WIDTH  = 6
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  mm_dims_type                  dims,
   output logic                         busy,
   output logic [ADDR_WIDTH-1:0]        rd_addr_a,
   output logic [ADDR_WIDTH-1:0]        rd_addr_b,
   input  wire signed [VALUE_WIDTH-1:0] rd_data_a,
   input  wire signed [VALUE_WIDTH-1:0] rd_data_b,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [IDX_WIDTH-1:0]         rsp_row,
   output logic [IDX_WIDTH-1:0]         rsp_col,
   output logic signed [ELEM_WIDTH-1:0] rsp_element,
   output logic                         rsp_last,
   output logic                         rsp_error
);
   localparam int DW = $clog2(MAX_DIM);
   localparam int PW = 2 * VALUE_WIDTH;
   localparam int XW = (PW > ELEM_WIDTH) ? PW : ELEM_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT,
      ST_ERROR
   } state_type;

   function automatic logic [DW-1:0] last_index(input logic [DIM_REG_WIDTH-1:0] r);
      logic [DIM_REG_WIDTH-1:0] t;
      if (r == '0) begin
         t = '0;
      end else if (r > DIM_REG_WIDTH'(MAX_DIM)) begin
         t = DIM_REG_WIDTH'(MAX_DIM - 1);
      end else begin
         t = r - 1'b1;
      end
      return t[DW-1:0];
   endfunction

   state_type                    state_ff, state_in;
   logic [DW-1:0]                i_ff, i_in;
   logic [DW-1:0]                j_ff, j_in;
   logic [DW-1:0]                k_ff, k_in;
   logic [DW-1:0]                ra_ff, ra_in;
   logic [DW-1:0]                ca_ff, ca_in;
   logic [DW-1:0]                cb_ff, cb_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [IDX_WIDTH-1:0]         rsp_row_ff, rsp_row_in;
   logic [IDX_WIDTH-1:0]         rsp_col_ff, rsp_col_in;
   logic signed [ELEM_WIDTH-1:0] rsp_element_ff, rsp_element_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_error_ff, rsp_error_in;

   logic                         issue;
   logic                         d1_valid_ff, d1_first_ff, d1_final_ff;
   logic                         p_valid_ff, p_first_ff, p_final_ff;
   logic                         acc_done_ff;
   logic signed [PW-1:0]         mult;
   logic signed [XW-1:0]         mult_x;
   logic signed [ELEM_WIDTH-1:0] prod_ff;
   logic signed [ELEM_WIDTH-1:0] acc_ff, acc_in;
   logic                         out_free;
   logic                         final_elem;

   assign issue      = (state_ff == ST_RUN);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign final_elem = (i_ff == ra_ff) && (j_ff == cb_ff);

   assign rd_addr_a = ADDR_WIDTH'(i_ff) * ADDR_WIDTH'(MAX_DIM) + ADDR_WIDTH'(k_ff);
   assign rd_addr_b = ADDR_WIDTH'(k_ff) * ADDR_WIDTH'(MAX_DIM) + ADDR_WIDTH'(j_ff);

   assign mult   = rd_data_a * rd_data_b;
   assign mult_x = XW'(mult);

   always_comb begin
      acc_in = acc_ff;
      if (p_valid_ff) begin
         acc_in = (p_first_ff ? '0 : acc_ff) + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
         acc_done_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         d1_valid_ff <= issue;
         p_valid_ff  <= d1_valid_ff;
         acc_done_ff <= p_valid_ff && p_final_ff;
         acc_ff      <= acc_in;
      end
      d1_first_ff <= (k_ff == '0);
      d1_final_ff <= (k_ff == ca_ff);
      p_first_ff  <= d1_first_ff;
      p_final_ff  <= d1_final_ff;
      prod_ff     <= mult_x[ELEM_WIDTH-1:0];
   end

   always_comb begin
      state_in       = state_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      ra_in          = ra_ff;
      ca_in          = ca_ff;
      cb_in          = cb_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_row_in     = rsp_row_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_error_in   = rsp_error_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ra_in = last_index(dims.rows_a);
               ca_in = last_index(dims.cols_a);
               cb_in = last_index(dims.cols_b);
               i_in  = '0;
               j_in  = '0;
               k_in  = '0;
               if (last_index(dims.cols_a) != last_index(dims.rows_b)) begin
                  state_in = ST_ERROR;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (k_ff == ca_ff) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (acc_done_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_row_in     = IDX_WIDTH'(i_ff);
               rsp_col_in     = IDX_WIDTH'(j_ff);
               rsp_element_in = acc_ff;
               rsp_last_in    = final_elem;
               rsp_error_in   = 1'b0;
               if (final_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  if (j_ff == cb_ff) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_row_in     = '0;
               rsp_col_in     = '0;
               rsp_element_in = '0;
               rsp_last_in    = 1'b1;
               rsp_error_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
      end
      ra_ff          <= ra_in;
      ca_ff          <= ca_in;
      cb_ff          <= cb_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_error_ff   <= rsp_error_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_row     = rsp_row_ff;
   assign rsp_col     = rsp_col_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_error   = rsp_error_ff;
endmodule
`default_nettype wire

// ===== rtl/mm_checker.sv =====
// Port-level checker of the matrix multiply core and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module mm_checker
   import mm_pkg::*;
(
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_ready,
   input wire [CMD_WIDTH-1:0]    req_command,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire [IDX_WIDTH-1:0]    rsp_out_row,
   input wire [IDX_WIDTH-1:0]    rsp_out_col,
   input wire [ELEM_WIDTH-1:0]   rsp_element,
   input wire                    rsp_last,
   input wire                    rsp_error
);
   `MM_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MM_ASSERT_NEXT(a_rsp_payload_holds, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_element) && $stable(rsp_last) && $stable(rsp_error))
   `MM_ASSERT_NEXT(a_start_blocks_requests, clock, reset, req_valid && req_ready && (req_command == CMD_START), !req_ready)
   `MM_ASSERT_NOW(a_error_shape, clock, reset, rsp_valid && rsp_error, rsp_last && (rsp_element == '0) && (rsp_out_row == '0) && (rsp_out_col == '0))
endmodule

bind matrix_multiply_core mm_checker u_mm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_command (req_bus.command),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_out_row (rsp_bus.out_row),
   .rsp_out_col (rsp_bus.out_col),
   .rsp_element (rsp_bus.element),
   .rsp_last    (rsp_bus.last),
   .rsp_error   (rsp_bus.error)
);
`default_nettype wire

// ===== bench/mm_product_checker.sv =====
// Checker that predicts matrix products from observed requests and compares the responses.
module mm_product_checker
   import mm_pkg::*;
#(
   parameter int MAX_DIM     = 8,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [CMD_WIDTH-1:0]          req_command,
   input  logic [IDX_WIDTH-1:0]          req_row,
   input  logic [IDX_WIDTH-1:0]          req_col,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [IDX_WIDTH-1:0]          rsp_out_row,
   input  logic [IDX_WIDTH-1:0]          rsp_out_col,
   input  logic signed [ELEM_WIDTH-1:0]  rsp_element,
   input  logic                          rsp_last,
   input  logic                          rsp_error,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [DIM_REG_WIDTH-1:0]      csr_wdata,
   output int                            fail_count,
   output int                            outstanding
);

   typedef struct packed {
      logic [IDX_WIDTH-1:0]         out_row;
      logic [IDX_WIDTH-1:0]         out_col;
      logic signed [ELEM_WIDTH-1:0] element;
      logic                         last;
      logic                         error;
   } c_element_type;

   c_element_type                 expected_elements[$];
   logic signed [VALUE_WIDTH-1:0] a_store [MAX_DIM*MAX_DIM];
   logic signed [VALUE_WIDTH-1:0] b_store [MAX_DIM*MAX_DIM];
   mm_dims_type                   dims;

   function automatic int dim_in_use(logic [DIM_REG_WIDTH-1:0] code);
      if (code == '0) return 1;
      if (code > MAX_DIM) return MAX_DIM;
      return int'(code);
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic predict_product();
      int            rows;
      int            inner;
      int            inner_b;
      int            cols;
      longint        sum;
      c_element_type c;
      rows    = dim_in_use(dims.rows_a);
      inner   = dim_in_use(dims.cols_a);
      inner_b = dim_in_use(dims.rows_b);
      cols    = dim_in_use(dims.cols_b);
      if (inner != inner_b) begin
         c.out_row = '0;
         c.out_col = '0;
         c.element = '0;
         c.last    = 1'b1;
         c.error   = 1'b1;
         expected_elements.push_back(c);
         return;
      end
      for (int i = 0; i < rows; i++) begin
         for (int j = 0; j < cols; j++) begin
            sum = 0;
            for (int k = 0; k < inner; k++) begin
               sum += longint'(a_store[i*MAX_DIM+k]) * longint'(b_store[k*MAX_DIM+j]);
            end
            c.out_row = IDX_WIDTH'(i);
            c.out_col = IDX_WIDTH'(j);
            c.element = ELEM_WIDTH'(sum);
            c.last    = (i == rows - 1) && (j == cols - 1);
            c.error   = 1'b0;
            expected_elements.push_back(c);
         end
      end
   endtask

   task automatic check_response();
      c_element_type want;
      if (expected_elements.size() == 0) begin
         report_mismatch($sformatf("unexpected response C[%0d][%0d] element %0d error %0b",
                                   rsp_out_row, rsp_out_col, rsp_element, rsp_error));
         return;
      end
      want = expected_elements.pop_front();
      if (rsp_out_row !== want.out_row)
         report_mismatch($sformatf("C[%0d][%0d] out_row expected %0d, got %0d",
                                   want.out_row, want.out_col, want.out_row, rsp_out_row));
      if (rsp_out_col !== want.out_col)
         report_mismatch($sformatf("C[%0d][%0d] out_col expected %0d, got %0d",
                                   want.out_row, want.out_col, want.out_col, rsp_out_col));
      if (rsp_element !== want.element)
         report_mismatch($sformatf("C[%0d][%0d] element expected %0d, got %0d",
                                   want.out_row, want.out_col, want.element, rsp_element));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("C[%0d][%0d] last expected %0b, got %0b",
                                   want.out_row, want.out_col, want.last, rsp_last));
      if (rsp_error !== want.error)
         report_mismatch($sformatf("C[%0d][%0d] error expected %0b, got %0b",
                                   want.out_row, want.out_col, want.error, rsp_error));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_elements.delete();
         dims        <= '{DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ROWS_A: dims.rows_a <= csr_wdata;
               REG_COLS_A: dims.cols_a <= csr_wdata;
               REG_ROWS_B: dims.rows_b <= csr_wdata;
               REG_COLS_B: dims.cols_b <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) check_response();
         if (req_valid && req_ready) begin
            case (req_command)
               CMD_LOAD_A: begin
                  if (req_row < MAX_DIM && req_col < MAX_DIM)
                     a_store[req_row*MAX_DIM+req_col] = req_value;
               end
               CMD_LOAD_B: begin
                  if (req_row < MAX_DIM && req_col < MAX_DIM)
                     b_store[req_row*MAX_DIM+req_col] = req_value;
               end
               CMD_START: predict_product();
               default: ;
            endcase
         end
         outstanding <= expected_elements.size();
      end
   end

endmodule

// ===== bench/tb.sv =====
// Testbench top of the matrix multiply core: stimulus, flow control, watchdog and verdict.
module tb;
   import mm_pkg::*;

   localparam int MAX_DIM       = 8;
   localparam int VALUE_WIDTH   = 16;
   localparam int ITEM_TARGET   = 400;
   localparam int IDLE_LIMIT    = 5000;
   localparam int LONG_HOLD     = 600;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [DIM_REG_WIDTH-1:0]   csr_wdata;
   int                         fail_count;
   int                         outstanding;
   int                         items_sent;
   int                         idle_cycles;
   int                         ra, ca, rb, cb;
   bit                         a_set [MAX_DIM*MAX_DIM];
   bit                         b_set [MAX_DIM*MAX_DIM];
   bit                         no_idle;
   bit                         long_hold_pending;

   mm_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_bus ();
   mm_rsp_if rsp_bus ();

   matrix_multiply_core #(
      .MAX_DIM    (MAX_DIM),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   mm_product_checker #(
      .MAX_DIM    (MAX_DIM),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_command(req_bus.command),
      .req_row    (req_bus.row),
      .req_col    (req_bus.col),
      .req_value  (req_bus.value),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_out_row(rsp_bus.out_row),
      .rsp_out_col(rsp_bus.out_col),
      .rsp_element(rsp_bus.element),
      .rsp_last   (rsp_bus.last),
      .rsp_error  (rsp_bus.error),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int gap_cycles();
      int pick;
      if (no_idle) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) return VALUE_MIN;
      if (pick < 25) return VALUE_MAX;
      if (pick < 30) return '0;
      if (pick < 35) return '1;
      return VALUE_WIDTH'($urandom());
   endfunction

   function automatic int dim_in_use(logic [DIM_REG_WIDTH-1:0] code);
      if (code == '0) return 1;
      if (code > MAX_DIM) return MAX_DIM;
      return int'(code);
   endfunction

   // Dimensions of one and of the maximum are sometimes written as zero or as an oversized code.
   function automatic logic [DIM_REG_WIDTH-1:0] dim_code(int in_use);
      if (in_use == 1 && $urandom_range(0, 3) == 0) return '0;
      if (in_use == MAX_DIM && $urandom_range(0, 2) == 0)
         return DIM_REG_WIDTH'($urandom_range(MAX_DIM + 1, 2**DIM_REG_WIDTH - 1));
      return DIM_REG_WIDTH'(in_use);
   endfunction

   task automatic send(logic [CMD_WIDTH-1:0] command, int row, int col,
                       logic signed [VALUE_WIDTH-1:0] value);
      int gap;
      gap = gap_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= command;
      req_bus.row     <= IDX_WIDTH'(row);
      req_bus.col     <= IDX_WIDTH'(col);
      req_bus.value   <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (command == CMD_LOAD_A) a_set[row*MAX_DIM+col] = 1'b1;
      if (command == CMD_LOAD_B) b_set[row*MAX_DIM+col] = 1'b1;
      if (command != CMD_UNUSED) items_sent++;
   endtask

   task automatic start_product();
      if (ca == rb) begin
         for (int i = 0; i < ra; i++)
            for (int k = 0; k < ca; k++)
               if (!a_set[i*MAX_DIM+k]) send(CMD_LOAD_A, i, k, random_value());
         for (int k = 0; k < rb; k++)
            for (int j = 0; j < cb; j++)
               if (!b_set[k*MAX_DIM+j]) send(CMD_LOAD_B, k, j, random_value());
      end
      send(CMD_START, $urandom_range(0, 7), $urandom_range(0, 7), random_value());
   endtask

   task automatic configure(logic [DIM_REG_WIDTH-1:0] code_ra, logic [DIM_REG_WIDTH-1:0] code_ca,
                            logic [DIM_REG_WIDTH-1:0] code_rb, logic [DIM_REG_WIDTH-1:0] code_cb);
      csr_we    <= 1'b1;
      csr_index <= REG_ROWS_A;
      csr_wdata <= code_ra;
      @(posedge clock);
      csr_index <= REG_COLS_A;
      csr_wdata <= code_ca;
      @(posedge clock);
      csr_index <= REG_ROWS_B;
      csr_wdata <= code_rb;
      @(posedge clock);
      csr_index <= REG_COLS_B;
      csr_wdata <= code_cb;
      @(posedge clock);
      csr_we <= 1'b0;
      ra = dim_in_use(code_ra);
      ca = dim_in_use(code_ca);
      rb = dim_in_use(code_rb);
      cb = dim_in_use(code_cb);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = gap_cycles();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   initial begin
      int size_a;
      int inner;
      int inner_b;
      int size_b;
      int pick;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= REG_ROWS_A;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.command <= CMD_LOAD_A;
      req_bus.row     <= '0;
      req_bus.col     <= '0;
      req_bus.value   <= '0;
      no_idle           = 1'b0;
      long_hold_pending = 1'b0;
      items_sent        = 0;
      ra = MAX_DIM;
      ca = MAX_DIM;
      rb = MAX_DIM;
      cb = MAX_DIM;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Zero dimension codes act as one; the unused command code must be ignored.
      configure('0, '0, '0, '0);
      send(CMD_LOAD_A, 0, 0, VALUE_MIN);
      send(CMD_LOAD_B, 0, 0, VALUE_MIN);
      send(CMD_UNUSED, 7, 7, VALUE_MAX);
      send(CMD_START, 0, 0, '0);
      send(CMD_LOAD_A, 0, 0, VALUE_MAX);
      send(CMD_START, 7, 7, '1);
      drain();

      // Inner dimension mismatches give a single error response.
      configure(4'd3, 4'd2, 4'd5, 4'd4);
      send(CMD_START, 0, 0, '0);
      drain();
      configure('1, '1, '0, '1);
      send(CMD_START, 0, 0, '0);
      drain();

      // Full size with the largest sum, while the response side holds off for a long time.
      configure('1, '1, '1, '1);
      for (int k = 0; k < MAX_DIM; k++) begin
         send(CMD_LOAD_A, 0, k, VALUE_MIN);
         send(CMD_LOAD_B, k, 0, VALUE_MIN);
      end
      start_product();
      long_hold_pending = 1'b1;
      repeat (6) send(CMD_LOAD_A, $urandom_range(0, 7), $urandom_range(0, 7), random_value());
      send(CMD_START, 0, 0, '0);
      drain();

      while (items_sent < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 99) < 60) begin
            size_a = $urandom_range(1, 3);
            inner  = $urandom_range(1, 3);
            size_b = $urandom_range(1, 3);
         end else begin
            size_a = $urandom_range(1, MAX_DIM);
            inner  = $urandom_range(1, MAX_DIM);
            size_b = $urandom_range(1, MAX_DIM);
         end
         inner_b = ($urandom_range(0, 99) < 12) ? $urandom_range(1, MAX_DIM) : inner;
         configure(dim_code(size_a), dim_code(inner), dim_code(inner_b), dim_code(size_b));
         repeat ($urandom_range(8, 30)) begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
               send(CMD_LOAD_A, $urandom_range(0, 7), $urandom_range(0, 7), random_value());
            else if (pick < 76)
               send(CMD_LOAD_B, $urandom_range(0, 7), $urandom_range(0, 7), random_value());
            else if (pick < 82)
               send(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), random_value());
            else
               start_product();
         end
         start_product();
         drain();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
